[rtl/core/psol_pkg.sv]
// Shared types and constants of the sustain-pedal solenoid scheduler.
`default_nettype none

package psol_pkg;

  // Opcodes of an input request
  localparam logic OP_PEDAL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_LEAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  // Pedal threshold and duty codes
  localparam logic [6:0] PRESS_MIN = 7'd64;
  localparam logic [7:0] DUTY_OFF  = 8'd0;
  localparam logic [7:0] DUTY_HOLD = 8'd30;
  localparam logic [7:0] DUTY_PULL = 8'd255;

  // Queue numbers
  localparam int unsigned Q_ACT   = 0;
  localparam int unsigned Q_ON    = 1;
  localparam int unsigned Q_DEACT = 2;
  localparam int unsigned Q_OFF   = 3;
  localparam int unsigned NUM_Q   = 4;

  typedef struct packed {
    logic        opcode;
    logic [6:0]  velocity;
    logic [31:0] now_ms;
  } psol_req_t;

  typedef struct packed {
    logic [7:0] drive_duty;
    logic       duty_written;
    logic       queue_overflow;
  } psol_res_t;

  // Operations on one time queue
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        set_back;
    logic        clear;
    logic [31:0] push_val;
    logic [31:0] back_val;
  } psol_qctl_t;

  // What a time queue shows
  typedef struct packed {
    logic        has_next;
    logic [31:0] next_val;
    logic [31:0] back_val;
    logic        overflow;
  } psol_qsts_t;

endpackage

`default_nettype wire

[rtl/core/pedal_solenoid_scheduler.sv]
// Top level of the sustain-pedal solenoid scheduler: sequencer, shared adder, config.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+----------------------------------
//  request   | start, busy, req_i                  | taken at edge with start && !busy
//  result    | res_valid_o, res_o                  | one-cycle strobe, cannot be held
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i    | written at edge with cfg_we_i
//
//  One 33-bit add/subtract unit does every time sum and every unsigned compare of
//  times, one operation per cycle, so the sequencer length sets the rate. A tick runs
//  four due checks of two compares each, then two timeout checks of a sum and
//  a compare. A press runs S_DUE, S_ACT, S_ACT_CMP[, S_SHIFT, S_MOVE_CMP], a release
//  S_DUE, S_REL_SUB, S_REL_CMP[, S_REL_ADD]. An ignored pedal request or one with
//  scheduling disabled never raises busy. The result strobe comes in the cycle after
//  the last step. Reset clears the queues to their reset contents at once; no clearing
//  pass. The receiver cannot stall, so a new request may be taken while a result shows.
`default_nettype none

module pedal_solenoid_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire psol_pkg::psol_req_t                   req_i,
  output logic                                       res_valid_o,
  output psol_pkg::psol_res_t                        res_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [psol_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [psol_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import psol_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_TK_NOW   = 13'b0000000000010,
    S_TK_ORD   = 13'b0000000000100,
    S_TO_SUM   = 13'b0000000001000,
    S_TO_CMP   = 13'b0000000010000,
    S_DUE      = 13'b0000000100000,
    S_ACT      = 13'b0000001000000,
    S_ACT_CMP  = 13'b0000010000000,
    S_SHIFT    = 13'b0000100000000,
    S_MOVE_CMP = 13'b0001000000000,
    S_REL_SUB  = 13'b0010000000000,
    S_REL_CMP  = 13'b0100000000000,
    S_REL_ADD  = 13'b1000000000000
  } state_e;

  // Due check order: (due queue, retired queue)
  localparam logic [1:0] CHK_OFF_DEACT = 2'd0;
  localparam logic [1:0] CHK_ACT_OFF   = 2'd1;
  localparam logic [1:0] CHK_ON_ACT    = 2'd2;
  localparam logic [1:0] CHK_DEACT_ON  = 2'd3;

  state_e state_q, state_d;
  logic [1:0]  chk_q, chk_d;
  logic        to_q, to_d;
  logic        flag_q, flag_d;
  logic        press_q, press_d;
  logic        pressed_q, pressed_d;
  logic [31:0] act_time_q, act_time_d;
  logic [7:0]  duty_q, duty_d;
  logic        wr_q, wr_d;
  logic        ovf_q, ovf_d;
  logic        res_valid_q;
  logic        fin;

  // Working registers: time of the request, due time and two derived times
  logic [31:0] now_q, now_d;
  logic [31:0] due_q, due_d;
  logic [31:0] tmp_q, tmp_d;
  logic [31:0] alt_q, alt_d;
  psol_res_t   res_q;

  // Configuration
  logic        sched_en_q;
  logic [15:0] full_delay_q;
  logic [15:0] on_lead_q;
  logic [15:0] off_lead_q;
  logic [31:0] timeout_q;

  // Shared add/subtract unit; carry out of a subtract is the a >= b compare
  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_r;
  logic [31:0] alu_y;
  logic        alu_ge;

  assign alu_r  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 33'(alu_sub);
  assign alu_y  = alu_r[31:0];
  assign alu_ge = alu_r[32];

  psol_qctl_t ctl [NUM_Q];
  psol_qsts_t sts [NUM_Q];

  psol_queue #(.DEPTH(QUEUE_DEPTH), .INIT_COUNT(1)) u_q_act (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl[Q_ACT]), .sts_o(sts[Q_ACT])
  );
  psol_queue #(.DEPTH(QUEUE_DEPTH), .INIT_COUNT(1)) u_q_on (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl[Q_ON]), .sts_o(sts[Q_ON])
  );
  psol_queue #(.DEPTH(QUEUE_DEPTH), .INIT_COUNT(1)) u_q_deact (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl[Q_DEACT]), .sts_o(sts[Q_DEACT])
  );
  psol_queue #(.DEPTH(QUEUE_DEPTH), .INIT_COUNT(2)) u_q_off (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl[Q_OFF]), .sts_o(sts[Q_OFF])
  );

  // Select the two queues of the current due check
  logic [31:0] ta, tb;
  logic        a_next, b_next;

  always_comb begin
    ta = sts[Q_OFF].next_val;  tb = sts[Q_DEACT].next_val;
    a_next = sts[Q_OFF].has_next;  b_next = sts[Q_DEACT].has_next;
    case (chk_q)
      CHK_ACT_OFF: begin
        ta = sts[Q_ACT].next_val;  tb = sts[Q_OFF].next_val;
        a_next = sts[Q_ACT].has_next;  b_next = sts[Q_OFF].has_next;
      end
      CHK_ON_ACT: begin
        ta = sts[Q_ON].next_val;  tb = sts[Q_ACT].next_val;
        a_next = sts[Q_ON].has_next;  b_next = sts[Q_ACT].has_next;
      end
      CHK_DEACT_ON: begin
        ta = sts[Q_DEACT].next_val;  tb = sts[Q_ON].next_val;
        a_next = sts[Q_DEACT].has_next;  b_next = sts[Q_ON].has_next;
      end
      default: ;
    endcase
  end

  logic req_press;
  logic ovf_any;

  assign req_press = (req_i.velocity >= PRESS_MIN);
  assign ovf_any   = sts[Q_ACT].overflow | sts[Q_ON].overflow |
                     sts[Q_DEACT].overflow | sts[Q_OFF].overflow;

  always_comb begin
    state_d    = state_q;
    chk_d      = chk_q;
    to_d       = to_q;
    flag_d     = flag_q;
    press_d    = press_q;
    pressed_d  = pressed_q;
    act_time_d = act_time_q;
    duty_d     = duty_q;
    wr_d       = (state_q == S_IDLE) ? 1'b0 : wr_q;
    now_d      = now_q;
    due_d      = due_q;
    tmp_d      = tmp_q;
    alt_d      = alt_q;
    fin        = 1'b0;
    alu_a      = now_q;
    alu_b      = '0;
    alu_sub    = 1'b0;
    for (int q = 0; q < NUM_Q; q++) begin
      ctl[q] = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          now_d   = req_i.now_ms;
          press_d = req_press;
          if (req_i.opcode == OP_TICK) begin
            chk_d   = CHK_OFF_DEACT;
            to_d    = 1'b0;
            state_d = S_TK_NOW;
          end else if (!sched_en_q) begin
            // Drive the duty straight from the pedal
            duty_d = req_press ? DUTY_PULL : DUTY_OFF;
            wr_d   = 1'b1;
            fin    = 1'b1;
          end else if (req_press && !pressed_q) begin
            pressed_d = 1'b1;
            state_d   = S_DUE;
          end else if (!req_press && pressed_q) begin
            pressed_d = 1'b0;
            state_d   = S_DUE;
          end else begin
            // Repeated press or release while off: nothing to schedule
            fin = 1'b1;
          end
        end
      end

      S_TK_NOW: begin
        alu_a   = now_q;
        alu_b   = ta;
        alu_sub = 1'b1;
        flag_d  = alu_ge && a_next && b_next;
        state_d = S_TK_ORD;
      end

      S_TK_ORD: begin
        alu_a   = ta;
        alu_b   = tb;
        alu_sub = 1'b1;
        if (flag_q && alu_ge) begin
          // Retire the head of the second queue and set its duty, except for the act queue
          case (chk_q)
            CHK_OFF_DEACT: begin ctl[Q_DEACT].pop = 1'b1; duty_d = DUTY_OFF;  wr_d = 1'b1; end
            CHK_ACT_OFF:   begin ctl[Q_OFF].pop   = 1'b1; duty_d = DUTY_PULL; wr_d = 1'b1; end
            CHK_ON_ACT:    begin ctl[Q_ACT].pop   = 1'b1; end
            default:       begin ctl[Q_ON].pop    = 1'b1; duty_d = DUTY_HOLD; wr_d = 1'b1; end
          endcase
        end
        if (chk_q == CHK_DEACT_ON) begin
          state_d = S_TO_SUM;
        end else begin
          chk_d   = chk_q + 2'd1;
          state_d = S_TK_NOW;
        end
      end

      S_TO_SUM: begin
        alu_a   = to_q ? sts[Q_ON].next_val : act_time_q;
        alu_b   = timeout_q;
        tmp_d   = alu_y;
        flag_d  = to_q ? sts[Q_ON].has_next : (act_time_q != '0);
        state_d = S_TO_CMP;
      end

      S_TO_CMP: begin
        alu_a   = now_q;
        alu_b   = tmp_q;
        alu_sub = 1'b1;
        if (flag_q && alu_ge) begin
          // Timeout: clear the schedule and mark off at the current time
          for (int q = 0; q < NUM_Q; q++) begin
            ctl[q].clear = 1'b1;
          end
          ctl[Q_OFF].push     = 1'b1;
          ctl[Q_OFF].push_val = now_q;
          act_time_d = '0;
          pressed_d  = 1'b0;
          duty_d     = DUTY_OFF;
          wr_d       = 1'b1;
        end
        if (!to_q) begin
          to_d    = 1'b1;
          state_d = S_TO_SUM;
        end else begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_DUE: begin
        alu_a   = now_q;
        alu_b   = {16'd0, full_delay_q};
        due_d   = alu_y;
        state_d = press_q ? S_ACT : S_REL_SUB;
      end

      S_ACT: begin
        alu_a   = due_q;
        alu_b   = {16'd0, on_lead_q};
        alu_sub = 1'b1;
        tmp_d   = alu_y;
        state_d = S_ACT_CMP;
      end

      S_ACT_CMP: begin
        alu_a   = tmp_q;
        alu_b   = sts[Q_OFF].back_val;
        alu_sub = 1'b1;
        if (alu_ge) begin
          ctl[Q_ACT].push     = 1'b1;
          ctl[Q_ACT].push_val = tmp_q;
          ctl[Q_ON].push      = 1'b1;
          ctl[Q_ON].push_val  = due_q;
          act_time_d = now_q;
          fin        = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        alu_a   = tmp_q;
        alu_b   = {16'd0, off_lead_q};
        alu_sub = 1'b1;
        alt_d   = alu_y;
        state_d = S_MOVE_CMP;
      end

      S_MOVE_CMP: begin
        alu_a   = alt_q;
        alu_b   = sts[Q_ON].back_val;
        alu_sub = 1'b1;
        if (alu_ge) begin
          // Move the last release back so this press can still be served
          ctl[Q_ON].set_back  = 1'b1;
          ctl[Q_ON].back_val  = alt_q;
          ctl[Q_OFF].set_back = 1'b1;
          ctl[Q_OFF].back_val = tmp_q;
          ctl[Q_ACT].push     = 1'b1;
          ctl[Q_ACT].push_val = tmp_q;
          ctl[Q_ON].push      = 1'b1;
          ctl[Q_ON].push_val  = due_q;
          act_time_d = now_q;
        end
        fin     = 1'b1;
        state_d = S_IDLE;
      end

      S_REL_SUB: begin
        alu_a   = due_q;
        alu_b   = {16'd0, off_lead_q};
        alu_sub = 1'b1;
        alt_d   = alu_y;
        state_d = S_REL_CMP;
      end

      S_REL_CMP: begin
        alu_a   = alt_q;
        alu_b   = sts[Q_ON].back_val;
        alu_sub = 1'b1;
        ctl[Q_DEACT].push     = 1'b1;
        ctl[Q_DEACT].push_val = alu_ge ? alt_q : due_q;
        if (alu_ge) begin
          ctl[Q_OFF].push     = 1'b1;
          ctl[Q_OFF].push_val = due_q;
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_REL_ADD;
        end
      end

      S_REL_ADD: begin
        alu_a   = due_q;
        alu_b   = {16'd0, off_lead_q};
        ctl[Q_OFF].push     = 1'b1;
        ctl[Q_OFF].push_val = alu_y;
        fin     = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    ovf_d = ((state_q == S_IDLE) ? 1'b0 : ovf_q) | ovf_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_q       <= CHK_OFF_DEACT;
      to_q        <= 1'b0;
      flag_q      <= 1'b0;
      press_q     <= 1'b0;
      pressed_q   <= 1'b0;
      act_time_q  <= '0;
      duty_q      <= DUTY_OFF;
      wr_q        <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      to_q        <= to_d;
      flag_q      <= flag_d;
      press_q     <= press_d;
      pressed_q   <= pressed_d;
      act_time_q  <= act_time_d;
      duty_q      <= duty_d;
      wr_q        <= wr_d;
      ovf_q       <= ovf_d;
      res_valid_q <= fin;
    end
  end

  // Hold working times and the result payload; no reset needed
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    due_q <= due_d;
    tmp_q <= tmp_d;
    alt_q <= alt_d;
    if (fin) begin
      res_q.drive_duty     <= duty_d;
      res_q.duty_written   <= wr_d;
      res_q.queue_overflow <= ovf_d;
    end
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_en_q   <= 1'b1;
      full_delay_q <= '0;
      on_lead_q    <= '0;
      off_lead_q   <= '0;
      timeout_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCHED_EN:   sched_en_q   <= cfg_wdata_i[0];
        CFG_FULL_DELAY: full_delay_q <= cfg_wdata_i[15:0];
        CFG_ON_LEAD:    on_lead_q    <= cfg_wdata_i[15:0];
        CFG_OFF_LEAD:   off_lead_q   <= cfg_wdata_i[15:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while the sequencer is still working");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o))
    else $error("accepted request neither worked on nor answered");

  a_duty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.drive_duty == DUTY_OFF || res_o.drive_duty == DUTY_HOLD ||
                     res_o.drive_duty == DUTY_PULL))
    else $error("drive duty is not one of off, hold, pull");

endmodule

`default_nettype wire

[rtl/core/psol_queue.sv]
// One time-ordered queue: head slot, next-due slot, tail cache, shift on pop.
`default_nettype none

module psol_queue #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned INIT_COUNT = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire psol_pkg::psol_qctl_t ctl_i,
  output psol_pkg::psol_qsts_t    sts_o
);
  import psol_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]   slot_q [DEPTH];
  logic [31:0]   slot_d [DEPTH];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   back_q, back_d;
  logic          full;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] next_idx;

  assign full     = (cnt_q == CW'(DEPTH));
  assign last_idx = IW'(cnt_q - CW'(1));
  assign next_idx = cnt_q[IW-1:0];

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    back_d = back_q;
    if (ctl_i.clear) begin
      // Cut back to the head, keep its value
      cnt_d  = CW'(1);
      back_d = slot_q[0];
      if (ctl_i.push) begin
        slot_d[1] = ctl_i.push_val;
        cnt_d     = CW'(2);
        back_d    = ctl_i.push_val;
      end
    end else if (ctl_i.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      cnt_d = cnt_q - CW'(1);
    end else begin
      if (ctl_i.set_back) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (IW'(i) == last_idx) slot_d[i] = ctl_i.back_val;
        end
        back_d = ctl_i.back_val;
      end
      // Drop a push into a full queue
      if (ctl_i.push && !full) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (IW'(i) == next_idx) slot_d[i] = ctl_i.push_val;
        end
        cnt_d  = cnt_q + CW'(1);
        back_d = ctl_i.push_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_q[i] <= '0;
      end
      cnt_q  <= CW'(INIT_COUNT);
      back_q <= '0;
    end else begin
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      back_q <= back_d;
    end
  end

  assign sts_o.has_next = (cnt_q >= CW'(2));
  assign sts_o.next_val = slot_q[1];
  assign sts_o.back_val = back_q;
  assign sts_o.overflow = ctl_i.push && !ctl_i.clear && full;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(DEPTH)))
    else $error("queue count out of range");

  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.pop && !ctl_i.clear) |-> (cnt_q >= CW'(2)) ##1 (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("pop without a due entry");

  a_pop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> !(ctl_i.push || ctl_i.set_back || ctl_i.clear))
    else $error("pop combined with another queue operation");

endmodule

`default_nettype wire
